### sv/greedy_word_wrap_splitter_defines.svh
// Assertion macros for the greedy word-wrap splitter checker.
// No dependencies; included by files that assert, which provide clk and rst_n.
`ifndef GREEDY_WORD_WRAP_SPLITTER_DEFINES_SVH
`define GREEDY_WORD_WRAP_SPLITTER_DEFINES_SVH

// Property checked outside reset.
`define GWWS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every edge, reset included.
`define GWWS_ASSERT_ANY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/gwws_pkg.sv
// Shared types and constants for the greedy word-wrap splitter.
// No dependencies; used by every module of the block.
`default_nettype none

package gwws_pkg;

  localparam int unsigned MAX_TEXT  = 65536;
  localparam int unsigned MAX_WIDTH = 255;

  localparam logic [7:0]  CH_NUL      = 8'h00;
  localparam logic [7:0]  CH_LF       = 8'h0a;
  localparam logic [7:0]  CH_CR       = 8'h0d;
  localparam logic [7:0]  CH_SP       = 8'h20;
  localparam logic [7:0]  WIDTH_RESET = 8'd38;
  localparam logic [7:0]  WIDTH_MAX   = 8'(MAX_WIDTH);
  localparam logic [15:0] POS_LIMIT   =
    ((MAX_TEXT - 1) < 65535) ? 16'(MAX_TEXT - 1) : 16'hffff;

  typedef enum logic {
    REC_LINE    = 1'b0,
    REC_SUMMARY = 1'b1
  } rec_kind_t;

  typedef struct packed {
    logic [15:0] start;
    logic [7:0]  len;
  } line_rec_t;

  // Slot 0: line from the byte itself, slot 1: flush at buffer end,
  // slot 2: summary record.
  typedef struct packed {
    logic [2:0]  vld;
    line_rec_t   brk;
    line_rec_t   fls;
    logic [15:0] total;
  } bundle_t;

endpackage

`default_nettype wire

### sv/gwws_core.sv
// Line-splitting state and the per-byte update for one text byte.
// Depends on gwws_pkg.
`default_nettype none

module gwws_core (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            step,
  input  wire logic [7:0]      char_byte,
  input  wire logic            end_of_buffer,
  input  wire logic [7:0]      line_width,
  output gwws_pkg::bundle_t    res
);

  logic [15:0] pos_r, pos_nxt;
  logic [15:0] cls_r, cls_nxt;
  logic [7:0]  cil_r, cil_nxt;
  logic [7:0]  lsi_r, lsi_nxt;
  logic        ss_r, ss_nxt;
  logic        skip_r, skip_nxt;
  logic        nul_r, nul_nxt;
  logic [15:0] le_r, le_nxt;

  function automatic logic [15:0] sat_pos(input logic [16:0] v);
    return (v > {1'b0, gwws_pkg::POS_LIMIT}) ? gwws_pkg::POS_LIMIT : v[15:0];
  endfunction

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == 16'hffff) ? v : v + 16'd1;
  endfunction

  always_comb begin
    logic [7:0] w;
    w = line_width;
    if (w == 8'd0) begin
      w = 8'd1;
    end else if (w > gwws_pkg::WIDTH_MAX) begin
      w = gwws_pkg::WIDTH_MAX;
    end

    res      = '0;
    cls_nxt  = cls_r;
    cil_nxt  = cil_r;
    lsi_nxt  = lsi_r;
    ss_nxt   = ss_r;
    skip_nxt = skip_r;
    nul_nxt  = nul_r;
    le_nxt   = le_r;

    if (!nul_r) begin
      skip_nxt = 1'b0;
      if (skip_r && char_byte == gwws_pkg::CH_LF) begin
        skip_nxt = 1'b0;
      end else if (char_byte == gwws_pkg::CH_NUL) begin
        if (cil_r != 8'd0) begin
          res.vld[0] = 1'b1;
          res.brk    = '{start: cls_r, len: cil_r};
        end
        cil_nxt = 8'd0;
        ss_nxt  = 1'b0;
        nul_nxt = 1'b1;
      end else if (char_byte == gwws_pkg::CH_LF || char_byte == gwws_pkg::CH_CR) begin
        res.vld[0] = 1'b1;
        res.brk    = '{start: cls_r, len: cil_r};
        cls_nxt    = sat_pos({1'b0, pos_r} + 17'd1);
        cil_nxt    = 8'd0;
        ss_nxt     = 1'b0;
        skip_nxt   = (char_byte == gwws_pkg::CH_CR);
      end else if (cil_r >= w) begin
        res.vld[0] = 1'b1;
        if (char_byte == gwws_pkg::CH_SP) begin
          res.brk = '{start: cls_r, len: cil_r};
          cls_nxt = sat_pos({1'b0, pos_r} + 17'd1);
          cil_nxt = 8'd0;
        end else if (ss_r) begin
          res.brk = '{start: cls_r, len: lsi_r};
          cls_nxt = sat_pos({1'b0, cls_r} + 17'(lsi_r) + 17'd1);
          cil_nxt = cil_r - lsi_r;
        end else begin
          res.brk = '{start: cls_r, len: cil_r};
          cls_nxt = pos_r;
          cil_nxt = 8'd1;
        end
        ss_nxt = 1'b0;
      end else begin
        if (char_byte == gwws_pkg::CH_SP) begin
          lsi_nxt = cil_r;
          ss_nxt  = 1'b1;
        end
        cil_nxt = cil_r + 8'd1;
      end
    end

    if (res.vld[0]) begin
      le_nxt = sat_inc(le_nxt);
    end

    pos_nxt = sat_pos({1'b0, pos_r} + 17'd1);

    if (end_of_buffer) begin
      if (!nul_nxt && cil_nxt != 8'd0) begin
        res.vld[1] = 1'b1;
        res.fls    = '{start: cls_nxt, len: cil_nxt};
        le_nxt     = sat_inc(le_nxt);
      end
      res.vld[2] = 1'b1;
      res.total  = le_nxt;
      pos_nxt    = '0;
      cls_nxt    = '0;
      cil_nxt    = '0;
      lsi_nxt    = '0;
      ss_nxt     = 1'b0;
      skip_nxt   = 1'b0;
      nul_nxt    = 1'b0;
      le_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      cls_r  <= '0;
      cil_r  <= '0;
      lsi_r  <= '0;
      ss_r   <= 1'b0;
      skip_r <= 1'b0;
      nul_r  <= 1'b0;
      le_r   <= '0;
    end else if (step) begin
      pos_r  <= pos_nxt;
      cls_r  <= cls_nxt;
      cil_r  <= cil_nxt;
      lsi_r  <= lsi_nxt;
      ss_r   <= ss_nxt;
      skip_r <= skip_nxt;
      nul_r  <= nul_nxt;
      le_r   <= le_nxt;
    end
  end

endmodule

`default_nettype wire

### sv/gwws_out.sv
// Result register: holds up to three records of one byte and sends them in order.
// Depends on gwws_pkg.
`default_nettype none

module gwws_out (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load,
  input  wire gwws_pkg::bundle_t bundle,
  output logic                   room,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   out_record_kind,
  output logic [15:0]            out_line_start,
  output logic [7:0]             out_line_len,
  output logic [15:0]            out_line_total,
  output logic                   out_run_last
);

  logic [2:0]          mask_r, mask_nxt;
  gwws_pkg::line_rec_t brk_r, fls_r;
  logic [15:0]         total_r;
  logic                xfer;
  logic                last;

  assign out_valid = |mask_r;
  assign last      = (mask_r & (mask_r - 3'd1)) == 3'd0;
  assign xfer      = out_valid && !out_stall;
  assign room      = !out_valid || (xfer && last);
  assign out_run_last = last;

  always_comb begin
    out_record_kind = gwws_pkg::REC_LINE;
    out_line_start  = '0;
    out_line_len    = '0;
    out_line_total  = '0;
    if (mask_r[0]) begin
      out_line_start = brk_r.start;
      out_line_len   = brk_r.len;
    end else if (mask_r[1]) begin
      out_line_start = fls_r.start;
      out_line_len   = fls_r.len;
    end else if (mask_r[2]) begin
      out_record_kind = gwws_pkg::REC_SUMMARY;
      out_line_total  = total_r;
    end
  end

  always_comb begin
    mask_nxt = mask_r;
    if (load) begin
      mask_nxt = bundle.vld;
    end else if (xfer) begin
      mask_nxt = mask_r & (mask_r - 3'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
    end else begin
      mask_r <= mask_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      brk_r   <= bundle.brk;
      fls_r   <= bundle.fls;
      total_r <= bundle.total;
    end
  end

endmodule

`default_nettype wire

### sv/greedy_word_wrap_splitter.sv
// Top level of the greedy word-wrap splitter: input register, width register,
// line state and result serialiser. Depends on gwws_pkg, gwws_core, gwws_out.
//
// Text bytes enter one per transfer and leave as line records (start offset and
// length) plus one summary record with the line count at each buffer end. A byte
// is registered at its transfer and processed once the output register has room
// for its records. The output register sends one record per cycle while out_stall
// is low, so a byte that causes k records (k at most 3) holds the output until all
// k are sent and a later byte with records waits behind it, stalling the input;
// bytes that cause zero or one record flow at one per cycle while out_stall is
// low. cfg_ready is always high and the width takes effect from the next byte
// processed.
`default_nettype none

module greedy_word_wrap_splitter (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_char_byte,
  input  wire logic        in_end_of_buffer,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_record_kind,
  output logic [15:0]      out_line_start,
  output logic [7:0]       out_line_len,
  output logic [15:0]      out_line_total,
  output logic             out_run_last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_line_width
);

  logic              vld_r;
  logic [7:0]        char_r;
  logic              eob_r;
  logic [7:0]        width_r;
  logic              room;
  logic              step;
  logic              in_xfer;
  gwws_pkg::bundle_t bundle;

  assign cfg_ready = 1'b1;
  assign step      = vld_r && (!(|bundle.vld) || room);
  assign in_stall  = vld_r && !step;
  assign in_xfer   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= 1'b0;
      width_r <= gwws_pkg::WIDTH_RESET;
    end else begin
      if (in_xfer) begin
        vld_r <= 1'b1;
      end else if (step) begin
        vld_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        width_r <= cfg_line_width;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      char_r <= in_char_byte;
      eob_r  <= in_end_of_buffer;
    end
  end

  gwws_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (step),
    .char_byte     (char_r),
    .end_of_buffer (eob_r),
    .line_width    (width_r),
    .res           (bundle)
  );

  gwws_out u_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (step && (|bundle.vld)),
    .bundle          (bundle),
    .room            (room),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_record_kind (out_record_kind),
    .out_line_start  (out_line_start),
    .out_line_len    (out_line_len),
    .out_line_total  (out_line_total),
    .out_run_last    (out_run_last)
  );

endmodule

`default_nettype wire

### sv/gwws_chk.sv
// Port checker for the greedy word-wrap splitter, bound to the top level.
// Depends on gwws_pkg and greedy_word_wrap_splitter_defines.svh.
`default_nettype none
`include "greedy_word_wrap_splitter_defines.svh"

module gwws_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        out_record_kind,
  input wire logic [15:0] out_line_start,
  input wire logic [7:0]  out_line_len,
  input wire logic [15:0] out_line_total,
  input wire logic        out_run_last
);

  logic        hold_req;
  logic        is_summary;
  logic        is_line;
  logic        line_zero;
  logic [40:0] rec_bus;

  assign hold_req   = out_valid && out_stall;
  assign is_summary = out_valid && (out_record_kind == gwws_pkg::REC_SUMMARY);
  assign is_line    = out_valid && (out_record_kind == gwws_pkg::REC_LINE);
  assign line_zero  = (out_line_start == 16'd0) && (out_line_len == 8'd0);
  assign rec_bus    = {out_record_kind, out_line_start, out_line_len, out_line_total};

  `GWWS_ASSERT_RST(a_out_hold, hold_req |=> out_valid && $stable(rec_bus), "stall moved record")
  `GWWS_ASSERT_RST(a_summary_last, is_summary |-> out_run_last, "summary not last of byte")
  `GWWS_ASSERT_RST(a_summary_zero, is_summary |-> line_zero, "summary carries line data")
  `GWWS_ASSERT_RST(a_line_total, is_line |-> out_line_total == 16'd0, "line carries a count")
  `GWWS_ASSERT_ANY(a_reset_idle, !rst_n |=> !out_valid && !in_stall, "busy after reset")

endmodule

bind greedy_word_wrap_splitter gwws_chk u_chk (.*);

`default_nettype wire

### bench/greedy_word_wrap_splitter_test.sv
// Self-checking bench for greedy_word_wrap_splitter: directed break, wrap, NUL and
// width cases, then random text under varied stalls and widths.
// Depends on gwws_pkg and the block's RTL only.
module greedy_word_wrap_splitter_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT    = 1_000_000;
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned LINE_COUNT_MAX = 65535;

  typedef struct packed {
    gwws_pkg::rec_kind_t kind;
    logic [15:0]         start;
    logic [7:0]          length;
    logic [15:0]         total;
    logic                last;
  } line_record_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_char_byte = '0;
  logic        in_end_of_buffer = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_record_kind;
  logic [15:0] out_line_start;
  logic [7:0]  out_line_len;
  logic [15:0] out_line_total;
  logic        out_run_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_line_width = '0;

  logic [7:0]   width_setting = gwws_pkg::WIDTH_RESET;
  int unsigned  text_pos = 0;
  int unsigned  line_begin = 0;
  int unsigned  line_chars = 0;
  int unsigned  space_at = 0;
  int unsigned  line_count = 0;
  bit           space_pending = 1'b0;
  bit           skip_lf = 1'b0;
  bit           halted_by_nul = 1'b0;
  line_record_t step_records[$];
  line_record_t pending_records[$];
  int unsigned  failures = 0;
  int unsigned  send_gap_pct = 0;
  int unsigned  recv_stall_pct = 0;
  int unsigned  cycles = 0;

  greedy_word_wrap_splitter uut (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic int unsigned clamp_offset(input int unsigned v);
    return (v > gwws_pkg::POS_LIMIT) ? gwws_pkg::POS_LIMIT : v;
  endfunction

  function automatic line_record_t make_record(input gwws_pkg::rec_kind_t kind,
                                               input int unsigned start_at,
                                               input int unsigned chars,
                                               input int unsigned count);
    line_record_t rec;
    rec.kind   = kind;
    rec.start  = 16'(start_at);
    rec.length = 8'(chars);
    rec.total  = 16'(count);
    rec.last   = 1'b0;
    return rec;
  endfunction

  function automatic void close_line(input int unsigned start_at, input int unsigned chars);
    step_records.push_back(make_record(gwws_pkg::REC_LINE, start_at, chars, 0));
    if (line_count < LINE_COUNT_MAX) line_count++;
  endfunction

  function automatic void clear_text_state();
    text_pos      = 0;
    line_begin    = 0;
    line_chars    = 0;
    space_at      = 0;
    space_pending = 1'b0;
    skip_lf       = 1'b0;
    halted_by_nul = 1'b0;
    line_count    = 0;
  endfunction

  function automatic void wrap_byte(input logic [7:0] ch, input logic eob);
    int unsigned  w;
    line_record_t rec;
    step_records.delete();
    w = (width_setting == 0) ? 1 : width_setting;
    if (w > gwws_pkg::WIDTH_MAX) w = gwws_pkg::WIDTH_MAX;
    if (!halted_by_nul) begin
      if (skip_lf && ch == gwws_pkg::CH_LF) begin
        skip_lf = 1'b0;
      end else begin
        skip_lf = 1'b0;
        if (ch == gwws_pkg::CH_NUL) begin
          if (line_chars > 0) close_line(line_begin, line_chars);
          line_chars    = 0;
          space_pending = 1'b0;
          halted_by_nul = 1'b1;
        end else if (ch == gwws_pkg::CH_LF || ch == gwws_pkg::CH_CR) begin
          close_line(line_begin, line_chars);
          line_begin    = clamp_offset(text_pos + 1);
          line_chars    = 0;
          space_pending = 1'b0;
          skip_lf       = (ch == gwws_pkg::CH_CR);
        end else if (line_chars >= w) begin
          if (ch == gwws_pkg::CH_SP) begin
            close_line(line_begin, line_chars);
            line_begin = clamp_offset(text_pos + 1);
            line_chars = 0;
          end else if (space_pending) begin
            close_line(line_begin, space_at);
            line_begin = clamp_offset(line_begin + space_at + 1);
            line_chars = line_chars - space_at;
          end else begin
            close_line(line_begin, line_chars);
            line_begin = text_pos;
            line_chars = 1;
          end
          space_pending = 1'b0;
        end else begin
          if (ch == gwws_pkg::CH_SP) begin
            space_at      = line_chars;
            space_pending = 1'b1;
          end
          line_chars++;
        end
      end
    end
    text_pos = clamp_offset(text_pos + 1);
    if (eob) begin
      if (!halted_by_nul && line_chars > 0) close_line(line_begin, line_chars);
      step_records.push_back(make_record(gwws_pkg::REC_SUMMARY, 0, 0, line_count));
      clear_text_state();
    end
    foreach (step_records[i]) begin
      rec = step_records[i];
      rec.last = (i == step_records.size() - 1);
      pending_records.push_back(rec);
    end
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      failures++;
      $error("%s: expected %0d, actual %0d", name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    line_record_t want;
    out_stall <= ($urandom_range(99, 0) < recv_stall_pct);
    if (rst_n && out_valid && !out_stall) begin
      if (pending_records.size() == 0) begin
        failures++;
        $error("line_start: expected no record, actual %0d", out_line_start);
      end else begin
        want = pending_records.pop_front();
        check_field("record_kind", 16'(want.kind), 16'(out_record_kind));
        check_field("line_start", want.start, out_line_start);
        check_field("line_len", 16'(want.length), 16'(out_line_len));
        check_field("line_total", want.total, out_line_total);
        check_field("run_last", 16'(want.last), 16'(out_run_last));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] ch, input logic eob);
    while ($urandom_range(99, 0) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_char_byte     <= ch;
    in_end_of_buffer <= eob;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    wrap_byte(ch, eob);
  endtask

  // '|' stands for LF, '~' for CR and '@' for NUL
  task automatic send_text(input string text, input logic eob);
    logic [7:0] ch;
    for (int i = 0; i < text.len(); i++) begin
      ch = text[i];
      case (ch)
        "|": ch = gwws_pkg::CH_LF;
        "~": ch = gwws_pkg::CH_CR;
        "@": ch = gwws_pkg::CH_NUL;
        default: ;
      endcase
      send_byte(ch, eob && (i == text.len() - 1));
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_records.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_line_width(input logic [7:0] w);
    wait_idle();
    cfg_valid      <= 1'b1;
    cfg_line_width <= w;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid     <= 1'b0;
    width_setting = w;
  endtask

  task automatic send_random_buffer(input int unsigned max_len, inout int unsigned sent);
    int unsigned len;
    int unsigned pick;
    logic [7:0]  ch;
    len = $urandom_range(max_len, 1);
    for (int unsigned i = 0; i < len; i++) begin
      pick = $urandom_range(99, 0);
      if (pick < 58) ch = 8'($urandom_range("z", "a"));
      else if (pick < 78) ch = gwws_pkg::CH_SP;
      else if (pick < 85) ch = gwws_pkg::CH_LF;
      else if (pick < 91) ch = gwws_pkg::CH_CR;
      else if (pick < 92) ch = gwws_pkg::CH_NUL;
      else ch = 8'($urandom_range(255, 0));
      send_byte(ch, i == len - 1);
    end
    sent += len;
  endtask

  task automatic test_line_breaks();
    send_text("a~|~", 1'b1);
    send_text("|", 1'b1);
  endtask

  task automatic test_wrapping();
    set_line_width(8'd3);
    send_text("a bcd efg|hijk", 1'b1);
  endtask

  task automatic test_nul_stop();
    send_text("@x", 1'b1);
    send_text("a@", 1'b0);
    send_byte(8'hff, 1'b1);
  endtask

  task automatic test_width_extremes();
    set_line_width(8'd0);
    send_text("ab", 1'b0);
    send_byte(8'hff, 1'b1);
  endtask

  task automatic test_width_lowered();
    set_line_width(gwws_pkg::WIDTH_MAX);
    send_text("ab cdefg", 1'b0);
    set_line_width(8'd2);
    send_text("h", 1'b1);
  endtask

  task automatic test_random_text(input int unsigned gap_pct, input int unsigned stall_pct,
                                  input int unsigned item_goal);
    int unsigned sent;
    int unsigned buffers;
    int unsigned pick;
    sent           = 0;
    buffers        = 0;
    send_gap_pct   = gap_pct;
    recv_stall_pct = stall_pct;
    while (sent < item_goal) begin
      if (buffers % 3 == 0) begin
        pick = $urandom_range(99, 0);
        if (pick < 10) set_line_width(8'd0);
        else if (pick < 20) set_line_width(gwws_pkg::WIDTH_MAX);
        else if (pick < 35) set_line_width(gwws_pkg::WIDTH_RESET);
        else set_line_width(8'($urandom_range(12, 1)));
      end
      send_random_buffer(48, sent);
      buffers++;
    end
  endtask

  initial begin
    send_gap_pct   = 11;
    recv_stall_pct = 82;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_line_breaks();
    test_wrapping();
    test_nul_stop();
    test_width_extremes();
    test_width_lowered();
    test_random_text(11, 82, 45);
    test_random_text(82, 11, 45);
    test_random_text(0, 0, 45);
    wait_idle();
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
